FILE: rtl/eptb_pkg.sv
// Package with shared types and constants of the edge-pair threshold binarizer.
package eptb_pkg;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_RADIUS = 2'd2;
    localparam logic [1:0] CFG_MAG    = 2'd3;

    localparam logic [7:0] FALLBACK_LEVEL = 8'd128;

    // Request handed from the sequencer to the divider.
    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [23:0] divisor;
    } div_req_t;

    // Gray value of one pixel, rounded.
    function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                           input logic [7:0] b);
        logic [24:0] acc;
        acc = 25'd4899 * {17'd0, r} + 25'd9617 * {17'd0, g} + 25'd1868 * {17'd0, b}
            + 25'd8192;
        return acc[21:14];
    endfunction

endpackage

FILE: rtl/eptb_divider.sv
// Restoring divider, one quotient bit per cycle.
module eptb_divider
    import eptb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  div_req_t    req,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient
);
    logic [31:0] quo_reg, quo_next;
    logic [24:0] rem_reg, rem_next;
    logic [23:0] den_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [24:0] trial;

    // One shift and compare step.
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[23:0], quo_reg[31]};
        if (busy_reg)
        begin
            quo_next = {quo_reg[30:0], 1'b0};
            if (trial >= {1'b0, den_reg})
            begin
                rem_next    = trial - {1'b0, den_reg};
                quo_next[0] = 1'b1;
            end
            else
                rem_next = trial;
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done_reg <= done_next;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd32;
            end
            else
            begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= 25'd0;
            den_reg <= req.divisor;
        end
        else
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

FILE: rtl/edge_pair_threshold_binarizer.sv
// Top level of the edge-pair threshold binarizer.
//  channel   dir  handshake                    payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata {red,green,blue}, tuser kind
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata {fallback,level,white}, tuser
//                                              is_summary, tlast frame_end
//  cfg       in   cfg_valid/cfg_ready          cfg_index, cfg_data
// A binarize pixel goes straight to the output register. An analyze pixel whose window fits
// walks the (2R+1)^2 window entries through the single read port of the ring memory;
// any other analyze pixel is only stored. The last one of a frame then starts the serial
// divider, waits while it runs (not when no pair was found) and lets the summary leave.
// The ring memory needs no clearing: entries never written are unused. The input stalls while
// the output register holds an untaken result.
module edge_pair_threshold_binarizer
    import eptb_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    parameter int MAX_RADIUS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // blue, green, red
    input  logic        s_axis_tuser,   // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // pixel_white, threshold_level, fallback_used, pad
    output logic        m_axis_tuser,   // is_summary
    output logic        m_axis_tlast,   // frame_end
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);
    localparam int RING = 2 * MAX_RADIUS + 1;
    localparam int XW   = $clog2(MAX_WIDTH);
    localparam int PW   = $clog2(MAX_WIDTH + 1);
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int RW   = $clog2(RING);
    localparam int RDW  = $clog2(MAX_RADIUS + 1);
    localparam int SW   = $clog2(2 * MAX_RADIUS + 1);
    localparam int AW   = $clog2(RING * MAX_WIDTH);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_LAST = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_WAIT = 3'd4;

    // Configuration registers.
    logic [11:0] width_reg, height_reg;
    logic [3:0]  radius_reg;
    logic [7:0]  mag_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 12'd640;
            height_reg <= 12'd480;
            radius_reg <= 4'd1;
            mag_reg    <= 8'd1;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_WIDTH:  width_reg  <= cfg_data;
                CFG_HEIGHT: height_reg <= cfg_data;
                CFG_RADIUS: radius_reg <= cfg_data[3:0];
                CFG_MAG:    mag_reg    <= cfg_data[7:0];
                default:    ;
            endcase
        end
    end

    // Clamped settings.
    logic [PW-1:0]  w_eff;
    logic [HW-1:0]  h_eff;
    logic [RDW-1:0] r_eff;
    logic [7:0]     m_eff;
    always_comb
    begin
        if (width_reg == 12'd0) w_eff = PW'(1);
        else if (32'(width_reg) > MAX_WIDTH) w_eff = PW'(MAX_WIDTH);
        else w_eff = PW'(width_reg);
        if (height_reg == 12'd0) h_eff = HW'(1);
        else if (32'(height_reg) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
        else h_eff = HW'(height_reg);
        if (radius_reg == 4'd0) r_eff = RDW'(1);
        else if (32'(radius_reg) > MAX_RADIUS) r_eff = RDW'(MAX_RADIUS);
        else r_eff = RDW'(radius_reg);
        m_eff = (mag_reg == 8'd0) ? 8'd1 : mag_reg;
    end

    // Ring memory of gray rows.
    logic [7:0]    ring_mem [RING*MAX_WIDTH];
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;
    always_ff @(posedge clk)
    begin
        if (mem_we)
            ring_mem[mem_waddr] <= mem_wdata;
        mem_rdata <= ring_mem[mem_raddr];
    end

    logic [2:0]    state_reg, state_next;
    logic [PW-1:0] acol_reg, bcol_reg;
    logic [HW-1:0] arow_reg, brow_reg;
    logic [RW-1:0] aslot_reg;
    logic [XW-1:0] px_reg;
    logic [RW-1:0] pslot_reg;
    logic [SW-1:0] wi_reg, wj_reg;
    logic          rd_v_reg, rd_c_reg;
    logic [7:0]    best_reg, ctr_reg;
    logic          last_reg;
    logic [30:0]   sum_reg;
    logic [22:0]   count_reg;
    logic [7:0]    thr_reg;
    logic          fb_reg;
    logic          ov_reg;
    logic [15:0]   od_reg;
    logic          ou_reg, ol_reg;
    div_req_t      dreq;
    logic          dbusy, ddone;
    logic [31:0]   dquo;

    eptb_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .busy(dbusy),
                        .done(ddone), .quotient(dquo));

    logic          accept;
    logic [7:0]    gray_in;
    logic [PW-1:0] an_col, bn_col;
    logic [HW-1:0] an_row, bn_row;
    logic          an_wrap, bn_wrap;
    logic [PW-1:0] span_w;
    logic          a_last, b_last, qualify;
    logic [RW-1:0] rd_slot;
    logic [RW:0]   slot_sum;
    logic [XW:0]   rd_x;
    logic [SW-1:0] span;
    logic          scan_end;

    assign s_axis_tready = (state_reg == ST_IDLE) && !ov_reg;
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign gray_in = gray_of(s_axis_tdata[23:16], s_axis_tdata[15:8], s_axis_tdata[7:0]);
    assign span    = SW'({r_eff, 1'b0});
    assign span_w  = PW'(span);

    // Position normalize for both passes.
    always_comb
    begin
        an_col = acol_reg; an_row = arow_reg; an_wrap = 1'b0;
        if (acol_reg >= w_eff)
        begin
            an_col = '0; an_row = arow_reg + HW'(1); an_wrap = 1'b1;
        end
        if (an_row >= h_eff) an_row = '0;
        bn_col = bcol_reg; bn_row = brow_reg; bn_wrap = 1'b0;
        if (bcol_reg >= w_eff)
        begin
            bn_col = '0; bn_row = brow_reg + HW'(1); bn_wrap = 1'b1;
        end
        if (bn_row >= h_eff) bn_row = '0;
        a_last  = (an_col + PW'(1) >= w_eff) && (32'(an_row) + 1 >= 32'(h_eff));
        b_last  = (bn_col + PW'(1) >= w_eff) && (32'(bn_row) + 1 >= 32'(h_eff));
        qualify = (an_col >= span_w) && (32'(an_row) >= 32'(span));
    end

    // Ring slot of the current row; aslot_reg follows the row counter modulo the ring.
    logic [RW-1:0] cur_slot, nxt_slot;
    always_comb
    begin
        cur_slot = aslot_reg;
        if (an_row == '0) cur_slot = '0;
        else if (an_wrap) cur_slot = (32'(aslot_reg) == RING - 1) ? '0 : aslot_reg + RW'(1);
        nxt_slot = (32'(cur_slot) == RING - 1) ? '0 : cur_slot + RW'(1);
    end

    // Read address of the window walk; a slot offset wraps within the ring.
    always_comb
    begin
        slot_sum = {1'b0, pslot_reg} + RW'(RING) - (RW + 1)'(wi_reg);
        rd_slot  = (32'(slot_sum) >= RING) ? RW'(32'(slot_sum) - RING) : RW'(slot_sum);
        rd_x     = {1'b0, px_reg} - (XW + 1)'(wj_reg);
        scan_end = (wi_reg == span) && (wj_reg == span);
    end

    always_comb
    begin
        mem_we    = accept && !s_axis_tuser;
        mem_waddr = AW'(32'(cur_slot) * MAX_WIDTH + 32'(an_col[XW-1:0]));
        mem_wdata = gray_in;
        mem_raddr = AW'(32'(rd_slot) * MAX_WIDTH + 32'(rd_x[XW-1:0]));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept && !s_axis_tuser)
                         state_next = qualify ? ST_SCAN : (a_last ? ST_DIV : ST_IDLE);
            ST_SCAN: if (scan_end) state_next = ST_LAST;
            ST_LAST: state_next = last_reg ? ST_DIV : ST_IDLE;
            ST_DIV:  state_next = ST_WAIT;
            ST_WAIT: if (ddone || count_reg == '0) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Window maximum including the read that lands in the last cycle.
    logic [7:0] best_fin;
    assign best_fin = (rd_v_reg && (mem_rdata > best_reg)) ? mem_rdata : best_reg;

    logic [8:0] pair;
    assign pair = {1'b0, best_fin} + {1'b0, ctr_reg};
    assign dreq.start    = (state_reg == ST_DIV) && (count_reg != '0);
    assign dreq.dividend = {1'b0, sum_reg} + 32'(count_reg);
    assign dreq.divisor  = {count_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            acol_reg <= '0; arow_reg <= '0; aslot_reg <= '0;
            bcol_reg <= '0; brow_reg <= '0;
            sum_reg <= '0; count_reg <= '0;
            thr_reg <= FALLBACK_LEVEL; fb_reg <= 1'b0;
            ov_reg <= 1'b0; rd_v_reg <= 1'b0; rd_c_reg <= 1'b0;
            wi_reg <= '0; wj_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ov_reg && m_axis_tready) ov_reg <= 1'b0;
            rd_v_reg <= state_reg == ST_SCAN;
            rd_c_reg <= (state_reg == ST_SCAN) && (32'(wi_reg) == 32'(r_eff))
                        && (32'(wj_reg) == 32'(r_eff));
            // Binarize pixel: result straight to the output register.
            if (accept && s_axis_tuser)
            begin
                bcol_reg <= bn_col + PW'(1) >= w_eff ? '0 : bn_col + PW'(1);
                brow_reg <= bn_col + PW'(1) >= w_eff ?
                            ((32'(bn_row) + 1 >= 32'(h_eff)) ? '0 : bn_row + HW'(1)) : bn_row;
                ov_reg <= 1'b1;
                od_reg <= {6'd0, fb_reg, thr_reg, (gray_in > thr_reg)};
                ou_reg <= 1'b0;
                ol_reg <= b_last;
            end
            // Analyze pixel: store and advance.
            if (accept && !s_axis_tuser)
            begin
                px_reg    <= an_col[XW-1:0];
                pslot_reg <= cur_slot;
                last_reg  <= a_last;
                best_reg  <= '0;
                wi_reg    <= '0;
                wj_reg    <= '0;
                if (a_last)
                begin
                    acol_reg <= '0; arow_reg <= '0; aslot_reg <= '0;
                end
                else if (an_col + PW'(1) >= w_eff)
                begin
                    acol_reg <= '0; arow_reg <= an_row + HW'(1); aslot_reg <= nxt_slot;
                end
                else
                begin
                    acol_reg <= an_col + PW'(1); arow_reg <= an_row; aslot_reg <= cur_slot;
                end
            end
            // Window walk, one memory read a cycle.
            if (state_reg == ST_SCAN && !scan_end)
            begin
                if (wj_reg == span)
                begin
                    wj_reg <= '0; wi_reg <= wi_reg + SW'(1);
                end
                else
                    wj_reg <= wj_reg + SW'(1);
            end
            if (rd_v_reg)
            begin
                if (mem_rdata > best_reg) best_reg <= mem_rdata;
                if (rd_c_reg) ctr_reg <= mem_rdata;
            end
            if (state_reg == ST_LAST && (best_fin - ctr_reg >= m_eff) && best_fin >= ctr_reg)
            begin
                sum_reg   <= sum_reg + 31'(pair);
                count_reg <= count_reg + 23'd1;
            end
            // Summary once the threshold is known.
            if (state_reg == ST_WAIT && (ddone || count_reg == '0))
            begin
                thr_reg   <= (count_reg == '0) ? FALLBACK_LEVEL : dquo[7:0];
                fb_reg    <= count_reg == '0;
                sum_reg   <= '0;
                count_reg <= '0;
                ov_reg    <= 1'b1;
                od_reg    <= {6'd0, (count_reg == '0),
                              (count_reg == '0) ? FALLBACK_LEVEL : dquo[7:0], 1'b0};
                ou_reg    <= 1'b1;
                ol_reg    <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
    assign m_axis_tuser  = ou_reg;
    assign m_axis_tlast  = ol_reg;

    // Never accept while a result waits.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted over pending result");
    // A summary always marks the frame end.
    a_summary_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("summary without frame end");
    // The divider only runs in the wait state.
    a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
        dbusy |-> state_reg == ST_WAIT)
        else $error("divider busy outside wait");
endmodule

FILE: test/eptb_checker.sv
`timescale 1ns / 1ps
// Checker that predicts the binarizer results from the observed requests and compares them.
module eptb_checker
    import eptb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data,
    output int          mismatch_count,
    output int          results_pending
);

    localparam int RING = 17;
    localparam int WMAX = 2048;
    localparam int HMAX = 2048;
    localparam int RMAX = 8;

    typedef struct packed {
        logic       is_summary;
        logic       white;
        logic [7:0] level;
        logic       fallback;
        logic       frame_end;
    } bin_result_t;

    bin_result_t expected_results[$];

    logic [7:0]  gray_ring[RING][WMAX];
    logic [11:0] reg_width, reg_height;
    logic [3:0]  reg_radius;
    logic [7:0]  reg_mag;
    int          an_col, an_row, bn_col, bn_row;
    longint      pair_sum, pair_count;
    logic [7:0]  level_now;
    logic        fallback_now;

    function automatic int clip(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Works out the result of one accepted pixel request, if any.
    function automatic void predict_pixel(input logic kind, input logic [23:0] px);
        int          w, h, rad, mag, span, luma, best, mid;
        logic        last;
        bin_result_t res;
        w = clip(reg_width, 1, WMAX);
        h = clip(reg_height, 1, HMAX);
        rad = clip(reg_radius, 1, RMAX);
        mag = clip(reg_mag, 1, 255);
        luma = ((4899 * px[23:16] + 9617 * px[15:8] + 1868 * px[7:0] + 8192) >> 14) & 255;
        if (!kind)
        begin
            if (an_col >= w)
            begin
                an_col = 0;
                an_row++;
            end
            if (an_row >= h)
                an_row = 0;
            gray_ring[an_row % RING][an_col] = luma[7:0];
            span = 2 * rad;
            if (an_col >= span && an_row >= span)
            begin
                best = 0;
                for (int i = 0; i <= span; i++)
                    for (int j = 0; j <= span; j++)
                        if (gray_ring[(an_row - i) % RING][an_col - j] > best)
                            best = gray_ring[(an_row - i) % RING][an_col - j];
                mid = gray_ring[(an_row - rad) % RING][an_col - rad];
                if (best - mid >= mag)
                begin
                    pair_sum += best + mid;
                    pair_count++;
                end
            end
            last = (an_col + 1 >= w) && (an_row + 1 >= h);
            an_col++;
            if (an_col >= w)
            begin
                an_col = 0;
                an_row++;
            end
            if (last)
            begin
                an_row = 0;
                if (pair_count == 0)
                begin
                    level_now = FALLBACK_LEVEL;
                    fallback_now = 1'b1;
                end
                else
                begin
                    level_now = 8'((pair_sum + pair_count) / (2 * pair_count));
                    fallback_now = 1'b0;
                end
                pair_sum = 0;
                pair_count = 0;
                res = '{1'b1, 1'b0, level_now, fallback_now, 1'b1};
                expected_results.push_back(res);
            end
        end
        else
        begin
            if (bn_col >= w)
            begin
                bn_col = 0;
                bn_row++;
            end
            if (bn_row >= h)
                bn_row = 0;
            last = (bn_col + 1 >= w) && (bn_row + 1 >= h);
            bn_col++;
            if (bn_col >= w)
            begin
                bn_col = 0;
                bn_row++;
            end
            if (bn_row >= h)
                bn_row = 0;
            res = '{1'b0, luma > level_now, level_now, fallback_now, last};
            expected_results.push_back(res);
        end
    endfunction

    // Tracks register writes and pixel requests, and checks every result taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_results.delete();
            reg_width = 12'd640;
            reg_height = 12'd480;
            reg_radius = 4'd1;
            reg_mag = 8'd1;
            an_col = 0;
            an_row = 0;
            bn_col = 0;
            bn_row = 0;
            pair_sum = 0;
            pair_count = 0;
            level_now = FALLBACK_LEVEL;
            fallback_now = 1'b0;
            mismatch_count = 0;
            results_pending = 0;
        end
        else
        begin
            bin_result_t got, want;
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = '{m_axis_tuser, m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tdata[9],
                        m_axis_tlast};
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result %p", $realtime, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got != want)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: result mismatch, expected %p, got %p",
                                     $realtime, want, got);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_WIDTH:  reg_width = cfg_data;
                    CFG_HEIGHT: reg_height = cfg_data;
                    CFG_RADIUS: reg_radius = cfg_data[3:0];
                    CFG_MAG:    reg_mag = cfg_data[7:0];
                    default:    ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_pixel(s_axis_tuser, s_axis_tdata);
            results_pending = expected_results.size();
        end
    end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps
// Top of the binarizer testbench: clock, reset, stimulus and verdict.
module testbench;
    import eptb_pkg::*;

    localparam logic KIND_ANALYZE  = 1'b0;
    localparam logic KIND_BINARIZE = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // blue, green, red
    logic        s_axis_tuser;    // kind
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;    // pixel_white, threshold_level, fallback_used, pad
    logic        m_axis_tuser;    // is_summary
    logic        m_axis_tlast;    // frame_end
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;
    int          mismatch_count;
    int          results_pending;

    int          burst_left;
    int          gap_limit;
    int          stall_mode;
    int          items_sent;
    bit          edgy_content;

    edge_pair_threshold_binarizer dut (.*);
    eptb_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #36_000_000;
        $display("[edge_pair_threshold_binarizer] ERROR");
        $finish;
    end

    // Receiver stalls follow a mode chosen per phase.
    always @(negedge clk)
    begin
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 4) == 0);
        endcase
    end

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_all(input int w, input int h, input int rad, input int mag);
        write_reg(CFG_WIDTH, 12'(w));
        write_reg(CFG_HEIGHT, 12'(h));
        write_reg(CFG_RADIUS, 12'(rad));
        write_reg(CFG_MAG, 12'(mag));
    endtask

    // Drains every expected result, then lets a slow pixel finish.
    task automatic wait_idle();
        while (results_pending != 0)
            @(negedge clk);
        repeat (400) @(negedge clk);
    endtask

    task automatic send_pixel(input logic kind, input logic [23:0] px);
        if (burst_left == 0)
        begin
            s_axis_tvalid = 1'b0;
            repeat ($urandom_range(0, gap_limit)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = px;
        s_axis_tuser = kind;
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    function automatic logic [23:0] make_pixel();
        if (!edgy_content)
            return 24'($urandom);
        if ($urandom_range(0, 3) == 0)
            return {8'($urandom_range(160, 255)), 8'($urandom_range(160, 255)),
                    8'($urandom_range(160, 255))};
        return {8'($urandom_range(0, 90)), 8'($urandom_range(0, 90)),
                8'($urandom_range(0, 90))};
    endfunction

    // One analyze frame and one binarize frame, their requests interleaved at random.
    task automatic run_frames(input int n);
        int left_an, left_bn;
        left_an = n;
        left_bn = n;
        while (left_an + left_bn > 0)
        begin
            if (left_bn == 0 || (left_an > 0 && $urandom_range(0, 2) != 0))
            begin
                send_pixel(KIND_ANALYZE, make_pixel());
                left_an--;
            end
            else
            begin
                send_pixel(KIND_BINARIZE, make_pixel());
                left_bn--;
            end
        end
        s_axis_tvalid = 1'b0;
        wait_idle();
    endtask

    initial
    begin
        int w, h, rad, mag;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = KIND_ANALYZE;
        cfg_valid = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data = '0;
        burst_left = 0;
        gap_limit = 0;
        stall_mode = 0;
        items_sent = 0;
        edgy_content = 1'b0;
        rst_n = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Single-pixel frame with the extreme colors; no pair can exist.
        write_all(1, 1, 1, 1);
        send_pixel(KIND_ANALYZE, 24'hFFFFFF);
        send_pixel(KIND_BINARIZE, 24'hFFFFFF);
        send_pixel(KIND_BINARIZE, 24'h000000);
        send_pixel(KIND_ANALYZE, 24'h000000);
        send_pixel(KIND_BINARIZE, 24'h808080);
        s_axis_tvalid = 1'b0;
        wait_idle();

        // Zero register values act as their least legal values.
        write_all(0, 0, 0, 0);
        send_pixel(KIND_ANALYZE, 24'hFF0000);
        send_pixel(KIND_BINARIZE, 24'h00FF00);
        s_axis_tvalid = 1'b0;
        wait_idle();

        // A checkerboard with the smallest threshold and radius finds pairs.
        write_all(3, 3, 1, 1);
        for (int i = 0; i < 9; i++)
            send_pixel(KIND_ANALYZE, (i % 2) ? 24'hFFFFFF : 24'h000000);
        for (int i = 0; i < 9; i++)
            send_pixel(KIND_BINARIZE, (i % 3) ? 24'h0000FF : 24'hFFFF00);
        s_axis_tvalid = 1'b0;
        wait_idle();

        // Clamped radius needs the largest window, on the smallest frame that holds it.
        stall_mode = 1;
        edgy_content = 1'b1;
        write_all(17, 4095, 15, 40);
        write_reg(CFG_HEIGHT, 12'd17);
        run_frames(289);

        // Random phases over small frames.
        while (items_sent < 700)
        begin
            stall_mode = $urandom_range(0, 2);
            gap_limit = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            edgy_content = ($urandom_range(0, 3) != 0);
            rad = $urandom_range(1, 3);
            w = $urandom_range(1, 2 * rad + 4);
            h = $urandom_range(1, 2 * rad + 4);
            case ($urandom_range(0, 3))
                0: mag = 1;
                1: mag = 255;
                2: mag = $urandom_range(0, 255);
                default: mag = $urandom_range(20, 120);
            endcase
            write_all(w, h, rad, mag);
            run_frames(w * h);
        end

        if (mismatch_count == 0 && results_pending == 0)
            $display("[edge_pair_threshold_binarizer] OK");
        else
            $display("[edge_pair_threshold_binarizer] ERROR");
        $finish;
    end

endmodule
